[rtl/phase_angle_dimmer_with_serial_set_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the phase-angle dimmer
// Concurrent checks that compile out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PHASE_ANGLE_DIMMER_WITH_SERIAL_SET_TOP_ASSERT_SVH
`define PHASE_ANGLE_DIMMER_WITH_SERIAL_SET_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PADIM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dimmer assertion failed: same-cycle implication");

// Next-cycle implication.
`define PADIM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dimmer assertion failed: next-cycle implication");

`else

`define PADIM_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PADIM_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

[rtl/padim_pkg.sv]
// ----------------------------------------------------------------------------
// padim_pkg
// Shared types and constants of the phase-angle dimmer.
// ----------------------------------------------------------------------------
package padim_pkg;

    localparam int NumChannelsDefault = 2;
    localparam int MaxChannels        = 4;
    localparam int LevelWidth         = 6;
    localparam int ChanWidth          = 2;
    localparam int CmdWidth           = 2;
    localparam int PinWidth           = 3;
    localparam int ApbAddrWidth       = 3;
    localparam int ApbDataWidth       = 32;
    localparam int ResultWidth        = 7;
    localparam int ByteWidth          = 8;

    localparam logic [LevelWidth-1:0] LevelOff      = 6'd36;
    localparam logic [LevelWidth-1:0] LastTickReset = 6'd35;

    // Register index of last_tick.
    localparam logic RegLastTick = 1'b0;

    typedef enum logic [CmdWidth-1:0] {
        CMD_ZERO_CROSS = 2'd0,
        CMD_PHASE_TICK = 2'd1,
        CMD_PIN_SAMPLE = 2'd2,
        CMD_RAMP_TICK  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RX_IDLE  = 2'd0,
        RX_HIGH  = 2'd1,
        RX_MID   = 2'd2,
        RX_LOW   = 2'd3
    } rx_state_t;

    typedef struct packed {
        logic                  valid;
        logic [ChanWidth-1:0]  channel;
        logic [LevelWidth-1:0] value;
    } rx_commit_t;

    typedef struct packed {
        rx_state_t  stage;
        rx_state_t  stage_next;
        rx_commit_t commit;
    } rx_status_t;

endpackage

[rtl/padim_rx.sv]
// ----------------------------------------------------------------------------
// padim_rx
// Serial level receiver: channel symbol then three 2-bit level parts.
// ----------------------------------------------------------------------------
module padim_rx (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         sample_en,
    input  logic [padim_pkg::PinWidth-1:0] sample_bits,
    output padim_pkg::rx_status_t        status
);
    import padim_pkg::*;

    rx_state_t             state_reg, state_next;
    logic [ChanWidth-1:0]  chan_reg, chan_next;
    logic [LevelWidth-1:0] value_reg, value_next;
    logic [PinWidth-1:0]   pins;
    logic                  pin_clk;
    logic [1:0]            pin_data;
    rx_commit_t            commit;

    // pins are active low
    assign pins     = ~sample_bits;
    assign pin_clk  = pins[2];
    assign pin_data = pins[1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            RX_IDLE: if (sample_en && pin_clk)  state_next = RX_HIGH;
            RX_HIGH: if (sample_en && !pin_clk) state_next = RX_MID;
            RX_MID:  if (sample_en && pin_clk)  state_next = RX_LOW;
            RX_LOW:  if (sample_en && !pin_clk) state_next = RX_IDLE;
            default: state_next = RX_IDLE;
        endcase
    end

    always_comb begin
        chan_next    = chan_reg;
        value_next   = value_reg;
        commit.valid = 1'b0;
        commit.channel = chan_reg;
        commit.value = value_reg | {4'b0000, pin_data};
        unique case (state_reg)
            RX_IDLE: begin
                if (sample_en && pin_clk) begin
                    chan_next  = pin_data;
                    value_next = '0;
                end
            end
            RX_HIGH: begin
                if (sample_en && !pin_clk) value_next = {pin_data, 4'b0000};
            end
            RX_MID: begin
                if (sample_en && pin_clk) value_next = value_reg | {2'b00, pin_data, 2'b00};
            end
            RX_LOW: begin
                commit.valid = sample_en && !pin_clk;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RX_IDLE;
        end else begin
            state_reg <= state_next;
        end
        chan_reg  <= chan_next;
        value_reg <= value_next;
    end

    assign status.stage      = state_reg;
    assign status.stage_next = state_next;
    assign status.commit     = commit;

endmodule

[rtl/padim_oq.sv]
// ----------------------------------------------------------------------------
// padim_oq
// Two-entry result queue; keeps input side open while a result waits.
// ----------------------------------------------------------------------------
module padim_oq #(
    parameter int Width = padim_pkg::ResultWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [Width-1:0] push_data,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Width-1:0] out_data
);
    import padim_pkg::*;

    logic [1:0]       count_reg, count_next;
    logic [Width-1:0] slot0_reg, slot0_next;
    logic [Width-1:0] slot1_reg, slot1_next;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign can_push  = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop) begin
            slot0_next = slot1_reg;
        end
        if (push) begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop)) begin
                slot0_next = push_data;
            end else begin
                slot1_next = push_data;
            end
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[rtl/phase_angle_dimmer_with_serial_set_top.sv]
// ----------------------------------------------------------------------------
// phase_angle_dimmer_with_serial_set_top
// Multi-channel phase-angle dimmer with serial level setting and ramping.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Payload
//  s_axis    in   tvalid/tready          tuser: command, tdata: sample_bits
//  m_axis    out  tvalid/tready          tdata: gate_outputs, busy_res, rx_stage
//  apb       in   psel/penable/pready    last_tick at byte address 0
//
//  One item per cycle while the queue has room: each event updates state in
//  the cycle it is accepted; its result enters a two-entry output queue.
//  Input stalls only when both queue entries hold untaken results.
//  Reset (aresetn, synchronous, active low) sets all levels and targets to
//  off (36), last_tick to 35, and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`include "phase_angle_dimmer_with_serial_set_top_assert.svh"

module phase_angle_dimmer_with_serial_set_top #(
    parameter int NUM_CHANNELS = padim_pkg::NumChannelsDefault
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [padim_pkg::ByteWidth-1:0]    s_axis_tdata,  // [2:0] sample_bits
    input  logic [padim_pkg::CmdWidth-1:0]     s_axis_tuser,  // [1:0] command
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] gate_outputs, [4] busy_res, [6:5] rx_stage
    output logic [padim_pkg::ByteWidth-1:0]    m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [padim_pkg::ApbAddrWidth-1:0] paddr,
    input  logic [padim_pkg::ApbDataWidth-1:0] pwdata,
    output logic [padim_pkg::ApbDataWidth-1:0] prdata,
    output logic                               pready
);
    import padim_pkg::*;

    localparam logic [2:0] NumCh = 3'(NUM_CHANNELS);

    // ---- configuration --------------------------------------------------
    logic [LevelWidth-1:0] last_tick_reg;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == RegLastTick) ?
                       {{(ApbDataWidth-LevelWidth){1'b0}}, last_tick_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_tick_reg <= LastTickReset;
        end else if (cfg_write && (paddr[2] == RegLastTick)) begin
            last_tick_reg <= pwdata[LevelWidth-1:0];
        end
    end

    // ---- input decode ----------------------------------------------------
    logic                in_accept;
    logic                q_can_push;
    cmd_t                cmd;
    logic [PinWidth-1:0] pin_bits;

    assign s_axis_tready = q_can_push;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cmd           = cmd_t'(s_axis_tuser);
    assign pin_bits      = s_axis_tdata[PinWidth-1:0];

    // ---- dimmer state ----------------------------------------------------
    logic [LevelWidth-1:0] level_reg  [NUM_CHANNELS];
    logic [LevelWidth-1:0] level_next [NUM_CHANNELS];
    logic [LevelWidth-1:0] target_reg [NUM_CHANNELS];
    logic [LevelWidth-1:0] target_next[NUM_CHANNELS];
    logic [LevelWidth-1:0] tick_reg, tick_next, tick_inc;
    logic                  tick_en_reg, tick_en_next;
    logic [MaxChannels-1:0] gate_reg, gate_next;
    logic                  ramping_reg, ramping_next;
    logic [ChanWidth-1:0]  ramp_ch_reg, ramp_ch_next;

    // per-channel compares against zero and against the advanced tick count
    logic [MaxChannels-1:0] match_zero, match_tick, chan_mask;

    // serial receiver; only sees samples while no ramp runs
    logic       rx_en;
    rx_status_t rx_status;

    assign rx_en = in_accept && (cmd == CMD_PIN_SAMPLE) && !ramping_reg;

    padim_rx u_rx (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (rx_en),
        .sample_bits (pin_bits),
        .status      (rx_status)
    );

    assign tick_inc = tick_reg + 6'd1;

    always_comb begin
        match_zero = '0;
        match_tick = '0;
        chan_mask  = '0;
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            chan_mask[n]  = 1'b1;
            match_zero[n] = (level_reg[n] == '0);
            match_tick[n] = (level_reg[n] == tick_inc);
        end
    end

    always_comb begin
        for (int n = 0; n < NUM_CHANNELS; n++) begin
            level_next[n]  = level_reg[n];
            target_next[n] = target_reg[n];
        end
        tick_next    = tick_reg;
        tick_en_next = tick_en_reg;
        gate_next    = gate_reg;
        ramping_next = ramping_reg;
        ramp_ch_next = ramp_ch_reg;
        if (in_accept) begin
            unique case (cmd)
                CMD_ZERO_CROSS: begin
                    // level zero fires right at the crossing
                    gate_next    = match_zero;
                    tick_next    = '0;
                    tick_en_next = 1'b1;
                end
                CMD_PHASE_TICK: begin
                    if (tick_en_reg) begin
                        tick_next = tick_inc;
                        gate_next = gate_reg | match_tick;
                        if (tick_inc == last_tick_reg) tick_en_next = 1'b0;
                    end
                end
                CMD_PIN_SAMPLE: begin
                    // out-of-range channel completes protocol, changes nothing
                    if (rx_status.commit.valid &&
                        ({1'b0, rx_status.commit.channel} < NumCh)) begin
                        ramp_ch_next = rx_status.commit.channel;
                        for (int n = 0; n < NUM_CHANNELS; n++) begin
                            if (ChanWidth'(n) == rx_status.commit.channel) begin
                                target_next[n] = rx_status.commit.value;
                                ramping_next   = (level_reg[n] != rx_status.commit.value);
                            end
                        end
                    end
                end
                CMD_RAMP_TICK: begin
                    if (!ramping_reg || ({1'b0, ramp_ch_reg} >= NumCh)) begin
                        ramping_next = 1'b0;
                    end else begin
                        for (int n = 0; n < NUM_CHANNELS; n++) begin
                            if (ChanWidth'(n) == ramp_ch_reg) begin
                                if (level_reg[n] < target_reg[n]) begin
                                    level_next[n] = level_reg[n] + 6'd1;
                                end else if (level_reg[n] > target_reg[n]) begin
                                    level_next[n] = level_reg[n] - 6'd1;
                                end
                                ramping_next = (level_next[n] != target_reg[n]);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                level_reg[n]  <= LevelOff;
                target_reg[n] <= LevelOff;
            end
            tick_reg    <= '0;
            tick_en_reg <= 1'b0;
            gate_reg    <= '0;
            ramping_reg <= 1'b0;
            ramp_ch_reg <= '0;
        end else begin
            for (int n = 0; n < NUM_CHANNELS; n++) begin
                level_reg[n]  <= level_next[n];
                target_reg[n] <= target_next[n];
            end
            tick_reg    <= tick_next;
            tick_en_reg <= tick_en_next;
            gate_reg    <= gate_next;
            ramping_reg <= ramping_next;
            ramp_ch_reg <= ramp_ch_next;
        end
    end

    // ---- result queue ----------------------------------------------------
    logic [ResultWidth-1:0] result, q_out;

    // state after the event: {rx_stage, busy, gates}
    assign result = {rx_status.stage_next, ramping_next, gate_next};

    padim_oq #(
        .Width (ResultWidth)
    ) u_oq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (result),
        .can_push  (q_can_push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (q_out)
    );

    assign m_axis_tdata = {{(ByteWidth-ResultWidth){1'b0}}, q_out};

    // ---- checks ----------------------------------------------------------
    // gates of nonexistent channels never drive
    `PADIM_ASSERT_IMP(a_gate_in_range, aclk, aresetn, 1'b1, ((gate_reg & ~chan_mask) == '0))
    // receiver sits idle for the whole ramp
    `PADIM_ASSERT_IMP(a_rx_idle_in_ramp, aclk, aresetn, ramping_reg,
                      (rx_status.stage == RX_IDLE))
    // a running ramp always names a real channel
    `PADIM_ASSERT_IMP(a_ramp_ch_valid, aclk, aresetn, ramping_reg, ({1'b0, ramp_ch_reg} < NumCh))
    // zero crossing restarts the phase count
    `PADIM_ASSERT_NXT(a_zc_restart, aclk, aresetn, in_accept && (cmd == CMD_ZERO_CROSS),
                      tick_en_reg && (tick_reg == '0))

endmodule
